// File: hw/rtl/mpsm_pkg.sv
// shared types and constants of the multi-pattern string matcher
// no dependencies
package mpsm_pkg;

  localparam int LETTER_W = 5;
  localparam int COUNT_W  = 16;
  localparam logic [COUNT_W-1:0] CNT_MAX = 16'hFFFF;
  localparam int Q_DEPTH  = 4;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_BUILD  = 2'd2,
    CMD_MATCH  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [LETTER_W-1:0] letter;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [COUNT_W-1:0] match_count;
    logic               text_done;
  } out_item_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [LETTER_W-1:0] letter;
    logic                last;
    logic                in_range;
  } qent_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR,
    ST_INS_RD,
    ST_INS_CHK,
    ST_INS_ROW,
    ST_INS_END_RD,
    ST_INS_END_WR,
    ST_B_INIT,
    ST_B_POP,
    ST_B_U,
    ST_B_CRD,
    ST_B_CCHK,
    ST_B_VL,
    ST_B_WRD,
    ST_B_WCHK,
    ST_B_WR,
    ST_M_RD,
    ST_M_CHK,
    ST_M_FL,
    ST_W_CHK,
    ST_W_ACC,
    ST_RESP
  } eng_state_t;

endpackage

// File: hw/rtl/mpsm_ram.sv
// generic single write port ram with registered read
// no dependencies
module mpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/mpsm_fifo.sv
// short command queue between front and engine
// depends on mpsm_pkg
module mpsm_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mpsm_pkg::qent_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output mpsm_pkg::qent_t rdata
);
  import mpsm_pkg::*;
  localparam int PW = $clog2(Q_DEPTH);

  qent_t        mem_r [Q_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == (PW+1)'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end
endmodule

// File: hw/rtl/mpsm_front.sv
// front end: takes input transfers and classifies them for the queue
// depends on mpsm_pkg
module mpsm_front #(
  parameter int ALPHABET = 26
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  mpsm_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               q_push,
  output mpsm_pkg::qent_t    q_entry
);
  import mpsm_pkg::*;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.cmd      = cmd_t'(in_data.cmd);
    q_entry.letter   = in_data.letter;
    q_entry.last     = in_data.last;
    q_entry.in_range = (9'(in_data.letter) < 9'(ALPHABET));
  end
endmodule

// File: hw/rtl/mpsm_engine.sv
// back end: trie, failure links and match walk sequencer with its rams
// depends on mpsm_pkg and mpsm_ram
module mpsm_engine #(
  parameter int NODES    = 1024,
  parameter int ALPHABET = 26
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  mpsm_pkg::qent_t     q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output mpsm_pkg::out_item_t out_data
);
  import mpsm_pkg::*;
  localparam int NW  = $clog2(NODES);
  localparam int KW  = $clog2(ALPHABET);
  localparam int CD  = NODES * ALPHABET;
  localparam int CAW = $clog2(CD);

  eng_state_t         state_r, state_nxt;
  qent_t              cur_r, cur_nxt;
  logic [NW:0]        used_r, used_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [NW-1:0]      ins_r, ins_nxt, mnode_r, mnode_nxt;
  logic [NW-1:0]      u_r, u_nxt, ch_r, ch_nxt, v_r, v_nxt, f_r, f_nxt, n_r, n_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [COUNT_W-1:0] text_r, text_nxt;
  logic               status_r, status_nxt, resp_r, resp_nxt;
  logic               ov_r, ov_nxt;
  out_item_t          od_r, od_nxt;

  logic           c_we, f_we, e_we, b_we;
  logic [CAW-1:0] c_wa, c_ra;
  logic [NW-1:0]  c_wd, c_rd, f_wa, f_ra, f_wd, f_rd, e_wa, e_ra, b_wa, b_ra, b_wd, b_rd;
  logic [COUNT_W-1:0] e_wd, e_rd;
  logic [COUNT_W:0]   sum;
  logic           k_last, done;

  function automatic logic [CAW-1:0] caddr(input logic [NW-1:0] node, input logic [7:0] idx);
    return CAW'(node) * CAW'(ALPHABET) + CAW'(idx);
  endfunction

  mpsm_ram #(.WIDTH(NW), .DEPTH(CD)) u_child (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  mpsm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  mpsm_ram #(.WIDTH(COUNT_W), .DEPTH(NODES)) u_end (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  mpsm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_bfs (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign k_last    = (k_r == KW'(ALPHABET - 1));
  assign done      = (cur_r.cmd == CMD_MATCH) && cur_r.last;
  assign sum       = (COUNT_W+1)'(text_r) + (COUNT_W+1)'(e_rd);

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    used_nxt   = used_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    ins_nxt    = ins_r;
    mnode_nxt  = mnode_r;
    u_nxt      = u_r;
    ch_nxt     = ch_r;
    v_nxt      = v_r;
    f_nxt      = f_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    text_nxt   = text_r;
    status_nxt = status_r;
    resp_nxt   = resp_r;
    ov_nxt     = (ov_r && out_ready) ? 1'b0 : ov_r;
    od_nxt     = od_r;
    q_pop      = 1'b0;
    c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
    f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
    e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
    b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = '0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cur_nxt    = q_entry;
          status_nxt = 1'b0;
          case (q_entry.cmd)
            CMD_CLEAR: begin
              k_nxt     = '0;
              resp_nxt  = 1'b1;
              state_nxt = ST_CLR;
            end
            CMD_INSERT: begin
              if (!q_entry.in_range) begin
                if (q_entry.last) begin
                  ins_nxt = '0;
                end
                state_nxt = ST_RESP;
              end else begin
                state_nxt = ST_INS_RD;
              end
            end
            CMD_BUILD: state_nxt = ST_B_INIT;
            CMD_MATCH: begin
              if (!q_entry.in_range) begin
                n_nxt     = '0;
                mnode_nxt = '0;
                state_nxt = ST_W_CHK;
              end else begin
                n_nxt     = mnode_r;
                state_nxt = ST_M_RD;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLR: begin
        c_we = 1'b1;
        c_wa = caddr('0, 8'(k_r));
        k_nxt = k_r + 1'b1;
        if (k_last) begin
          used_nxt  = (NW+1)'(1);
          ins_nxt   = '0;
          mnode_nxt = '0;
          text_nxt  = '0;
          state_nxt = resp_r ? ST_RESP : ST_IDLE;
        end
      end
      ST_INS_RD: begin
        c_ra = caddr(ins_r, 8'(cur_r.letter));
        state_nxt = ST_INS_CHK;
      end
      ST_INS_CHK: begin
        if (c_rd != '0) begin
          ins_nxt   = c_rd;
          state_nxt = cur_r.last ? ST_INS_END_RD : ST_RESP;
        end else if (used_r == (NW+1)'(NODES)) begin
          status_nxt = 1'b1;
          if (cur_r.last) begin
            ins_nxt = '0;
          end
          state_nxt = ST_RESP;
        end else begin
          c_we = 1'b1;
          c_wa = caddr(ins_r, 8'(cur_r.letter));
          c_wd = used_r[NW-1:0];
          f_we = 1'b1;
          f_wa = used_r[NW-1:0];
          e_we = 1'b1;
          e_wa = used_r[NW-1:0];
          ins_nxt   = used_r[NW-1:0];
          used_nxt  = used_r + 1'b1;
          k_nxt     = '0;
          state_nxt = ST_INS_ROW;
        end
      end
      ST_INS_ROW: begin
        c_we  = 1'b1;
        c_wa  = caddr(ins_r, 8'(k_r));
        k_nxt = k_r + 1'b1;
        if (k_last) begin
          state_nxt = cur_r.last ? ST_INS_END_RD : ST_RESP;
        end
      end
      ST_INS_END_RD: begin
        e_ra = ins_r;
        state_nxt = ST_INS_END_WR;
      end
      ST_INS_END_WR: begin
        if (e_rd != CNT_MAX) begin
          e_we = 1'b1;
          e_wa = ins_r;
          e_wd = e_rd + 1'b1;
        end
        ins_nxt   = '0;
        state_nxt = ST_RESP;
      end
      ST_B_INIT: begin
        f_we = 1'b1;
        b_we = 1'b1;
        head_nxt  = '0;
        tail_nxt  = (NW+1)'(1);
        state_nxt = ST_B_POP;
      end
      ST_B_POP: begin
        b_ra = head_r[NW-1:0];
        if (head_r < tail_r) begin
          head_nxt  = head_r + 1'b1;
          state_nxt = ST_B_U;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_B_U: begin
        u_nxt     = b_rd;
        k_nxt     = '0;
        state_nxt = ST_B_CRD;
      end
      ST_B_CRD: begin
        c_ra = caddr(u_r, 8'(k_r));
        state_nxt = ST_B_CCHK;
      end
      ST_B_CCHK: begin
        f_ra = u_r;
        ch_nxt = c_rd;
        if (c_rd == '0) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = k_last ? ST_B_POP : ST_B_CRD;
        end else if (u_r == '0) begin
          f_nxt     = '0;
          state_nxt = ST_B_WR;
        end else begin
          state_nxt = ST_B_VL;
        end
      end
      ST_B_VL: begin
        v_nxt     = f_rd;
        state_nxt = ST_B_WRD;
      end
      ST_B_WRD: begin
        c_ra = caddr(v_r, 8'(k_r));
        state_nxt = ST_B_WCHK;
      end
      ST_B_WCHK: begin
        f_ra = v_r;
        if (c_rd != '0) begin
          f_nxt     = c_rd;
          state_nxt = ST_B_WR;
        end else if (v_r == '0) begin
          f_nxt     = '0;
          state_nxt = ST_B_WR;
        end else begin
          state_nxt = ST_B_VL;
        end
      end
      ST_B_WR: begin
        f_we = 1'b1;
        f_wa = ch_r;
        f_wd = f_r;
        if (tail_r < (NW+1)'(NODES)) begin
          b_we     = 1'b1;
          b_wa     = tail_r[NW-1:0];
          b_wd     = ch_r;
          tail_nxt = tail_r + 1'b1;
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = k_last ? ST_B_POP : ST_B_CRD;
      end
      ST_M_RD: begin
        c_ra = caddr(n_r, 8'(cur_r.letter));
        state_nxt = ST_M_CHK;
      end
      ST_M_CHK: begin
        f_ra = n_r;
        if (c_rd != '0) begin
          n_nxt     = c_rd;
          mnode_nxt = c_rd;
          state_nxt = ST_W_CHK;
        end else if (n_r == '0) begin
          mnode_nxt = '0;
          state_nxt = ST_W_CHK;
        end else begin
          state_nxt = ST_M_FL;
        end
      end
      ST_M_FL: begin
        n_nxt     = f_rd;
        state_nxt = ST_M_RD;
      end
      ST_W_CHK: begin
        e_ra = n_r;
        f_ra = n_r;
        state_nxt = (n_r == '0) ? ST_RESP : ST_W_ACC;
      end
      ST_W_ACC: begin
        text_nxt  = sum[COUNT_W] ? CNT_MAX : sum[COUNT_W-1:0];
        e_we      = 1'b1;
        e_wa      = n_r;
        n_nxt     = f_rd;
        state_nxt = ST_W_CHK;
      end
      ST_RESP: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          od_nxt.status      = status_r;
          od_nxt.match_count = text_r;
          od_nxt.text_done   = done;
          if (done) begin
            text_nxt  = '0;
            mnode_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      resp_r   <= 1'b0;
      k_r      <= '0;
      ov_r     <= 1'b0;
      used_r   <= (NW+1)'(1);
      ins_r    <= '0;
      mnode_r  <= '0;
      text_r   <= '0;
      status_r <= 1'b0;
      head_r   <= '0;
      tail_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      resp_r   <= resp_nxt;
      k_r      <= k_nxt;
      ov_r     <= ov_nxt;
      used_r   <= used_nxt;
      ins_r    <= ins_nxt;
      mnode_r  <= mnode_nxt;
      text_r   <= text_nxt;
      status_r <= status_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
    end
    cur_r <= cur_nxt;
    u_r   <= u_nxt;
    ch_r  <= ch_nxt;
    v_r   <= v_nxt;
    f_r   <= f_nxt;
    n_r   <= n_nxt;
    od_r  <= od_nxt;
  end
endmodule

// File: hw/rtl/multi_pattern_string_matcher.sv
// top level of the multi-pattern string matcher
// depends on mpsm_pkg, mpsm_front, mpsm_fifo and mpsm_engine
//
//  channel  handshake            payload
//  in       in_valid/in_ready    in_data  (cmd, letter, last)
//  out      out_valid/out_ready  out_data (status, match_count, text_done)
//
// one result per item; the engine sequences one item at a time through its rams
// insert: walks down the trie by one letter; a new node also has its child row of ALPHABET entries
//   cleared (row clear)
// match: follows failure links until a child is found, then walks the failure chain adding end counts
// build: breadth-first pass over the trie that sets the failure link of every non-root child
// clear: clears the root row and empties the trie; after reset the root row is cleared as well
// a 4-entry queue and the output register let either side stall
module multi_pattern_string_matcher #(
  parameter int NODES    = 1024,
  parameter int ALPHABET = 26
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mpsm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mpsm_pkg::out_item_t out_data
);
  import mpsm_pkg::*;

  qent_t f_entry, q_entry;
  logic  q_full, q_push, q_pop, q_valid;

  mpsm_front #(.ALPHABET(ALPHABET)) u_front (
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .q_full(q_full), .q_push(q_push), .q_entry(f_entry));

  mpsm_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(f_entry), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .rdata(q_entry));

  mpsm_engine #(.NODES(NODES), .ALPHABET(ALPHABET)) u_engine (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));
endmodule

// File: hw/rtl/mpsm_checker.sv
// port-level checks for the multi-pattern string matcher, with bind
// depends on mpsm_pkg; binds into multi_pattern_string_matcher
module mpsm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input mpsm_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input mpsm_pkg::out_item_t out_data
);
  import mpsm_pkg::*;

  logic [7:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.status && out_data.text_done))
    else $error("full status on a match result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> pend_r != '0)
    else $error("result without a pending item");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready && in_data.cmd == CMD_MATCH |=> in_valid)
    else $error("input valid dropped");
endmodule

bind multi_pattern_string_matcher mpsm_checker u_mpsm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
  .out_data(out_data));
